>>> design/dcvt_pkg.sv
// Shared types, constants and segment table for the valve timer.
`timescale 1ns / 1ps

package dcvt_pkg;

    // Register indexes on the configuration port (word address bits [3:2]).
    localparam logic [1:0] REG_MAX_SECONDS    = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd1;
    localparam logic [1:0] REG_OFF_HOLD_TICKS = 2'd2;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Segment patterns, bit 7 is the dot.
    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_H     = 8'h37;
    localparam logic [7:0] SEG_E     = 8'h4F;
    localparam logic [7:0] SEG_L     = 8'h0E;
    localparam logic [7:0] SEG_O     = 8'h1D;
    localparam logic [7:0] SEG_F     = 8'h47;

    // Operating phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_COUNT = 3'b010,
        PH_HOLD  = 3'b100
    } t_phase;

    // What the display currently shows.
    typedef enum logic [1:0] {
        DISP_HELLO = 2'd0,
        DISP_OFF   = 2'd1,
        DISP_COUNT = 2'd2
    } t_disp_mode;

    typedef struct packed {
        logic       func;
        logic       button_low;
        logic [9:0] adc_value;
    } t_in_item;

    typedef struct packed {
        logic       valve_on;
        logic [7:0] seg_units;
        logic [7:0] seg_tens;
        logic [7:0] seg_hundreds;
        logic [7:0] seg_thousands;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic [7:0] max_seconds;
        logic [7:0] debounce_limit;
        logic [9:0] off_hold_ticks;
    } t_cfg;

    // Snapshot handed from the control stage to the display stage.
    // disp_half is floor(count/2); disp_q1 is floor(disp_half/100).
    typedef struct packed {
        logic        valve_on;
        logic        busy;
        t_disp_mode  disp_mode;
        logic [14:0] disp_half;
        logic [8:0]  disp_q1;
    } t_mid;

    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h7E;
            4'd1:    s = 8'h30;
            4'd2:    s = 8'h6D;
            4'd3:    s = 8'h79;
            4'd4:    s = 8'h33;
            4'd5:    s = 8'h5B;
            4'd6:    s = 8'h5F;
            4'd7:    s = 8'h70;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h7B;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

>>> design/debounced_countdown_valve_timer.sv
// Top level of the debounced countdown valve timer.
`timescale 1ns / 1ps
// Pipeline: two register stages; the control stage registers a snapshot of each accepted
//   input transaction and the decode stage registers the result transaction from it.
// Throughput: one transaction per cycle; a stalled result holds the decode stage, an empty
//   control stage takes one more transaction, then input stalls until the result leaves.
// Reset (synchronous, active low): registers return to their defaults, the timer goes
//   idle with the valve closed, the display shows HELLO and both pipeline stages empty.

module debounced_countdown_valve_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dcvt_pkg::t_in_item            i_in_data,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dcvt_pkg::t_out_item           o_out_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcvt_pkg::PADDR_W-1:0]  paddr,
    input  logic [dcvt_pkg::PDATA_W-1:0]  pwdata,
    output logic [dcvt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    dcvt_pkg::t_cfg cfg;
    logic           mid_valid;
    logic           mid_ready;
    dcvt_pkg::t_mid mid_data;

    // Register file: max_seconds, debounce_limit, off_hold_ticks.
    dcvt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stage 1: all state updates happen on the accepting edge; the
    // post-update snapshot (valve, busy, display source) is registered.
    // The count refresh stores floor(count/2) and its hundreds quotient
    // so only small divides by ten are left for later.
    dcvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_mid_valid (mid_valid),
        .i_mid_ready (mid_ready),
        .o_mid_data  (mid_data)
    );

    // Stage 2: split into four decimal digits, map to segment patterns,
    // register the result transaction.
    dcvt_disp u_disp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid_data  (mid_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/dcvt_cfg.sv
// APB-style configuration register file.
`timescale 1ns / 1ps

module dcvt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcvt_pkg::PADDR_W-1:0]  paddr,
    input  logic [dcvt_pkg::PDATA_W-1:0]  pwdata,
    output logic [dcvt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dcvt_pkg::t_cfg                o_cfg
);

    logic [7:0] r_max_seconds;
    logic [7:0] r_debounce_limit;
    logic [9:0] r_off_hold_ticks;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seconds    <= 8'd90;
            r_debounce_limit <= 8'd255;
            r_off_hold_ticks <= 10'd200;
        end else if (wr_en) begin
            unique case (reg_idx)
                dcvt_pkg::REG_MAX_SECONDS:    r_max_seconds    <= pwdata[7:0];
                dcvt_pkg::REG_DEBOUNCE_LIMIT: r_debounce_limit <= pwdata[7:0];
                dcvt_pkg::REG_OFF_HOLD_TICKS: r_off_hold_ticks <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dcvt_pkg::REG_MAX_SECONDS:    prdata = {24'd0, r_max_seconds};
            dcvt_pkg::REG_DEBOUNCE_LIMIT: prdata = {24'd0, r_debounce_limit};
            dcvt_pkg::REG_OFF_HOLD_TICKS: prdata = {22'd0, r_off_hold_ticks};
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg = '{max_seconds:    r_max_seconds,
                     debounce_limit: r_debounce_limit,
                     off_hold_ticks: r_off_hold_ticks};

endmodule

>>> design/dcvt_ctrl.sv
// Debounce, run flag, countdown and hold sequencing; registers one snapshot per transaction.
`timescale 1ns / 1ps

module dcvt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcvt_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dcvt_pkg::t_in_item i_in_data,
    output logic               o_mid_valid,
    input  logic               i_mid_ready,
    output dcvt_pkg::t_mid     o_mid_data
);

    dcvt_pkg::t_phase     r_phase,       n_phase;
    logic                 r_run_enabled, n_run_enabled;
    logic [15:0]          r_ticks_left,  n_ticks_left;
    logic [7:0]           r_press_count, n_press_count;
    logic                 r_press_taken, n_press_taken;
    logic [9:0]           r_hold_left,   n_hold_left;
    logic                 r_valve,       n_valve;
    dcvt_pkg::t_disp_mode r_disp_mode,   n_disp_mode;
    logic [14:0]          r_disp_half,   n_disp_half;
    logic [8:0]           r_disp_q1,     n_disp_q1;

    logic                 r_mid_valid;
    dcvt_pkg::t_mid       r_mid;
    logic                 accept;

    // Start value: max_seconds * floor(200*adc/1023).
    // With x = 1024*a + b, floor(x/1023) = a + ((a + b) >= 1023) since a + b < 2046.
    logic [17:0] adc_x200;
    logic [10:0] adc_sum;
    logic [7:0]  adc_scaled;
    logic [15:0] load_val;

    // ticks_left % 10 == 0 test via reciprocal 52429 / 2^19 (exact below 2^18).
    logic [31:0] t_prod;
    logic [12:0] t_div10;
    logic        t_mult10;

    // floor(ticks/2) / 100 via reciprocal 41944 / 2^22 (exact below 2^15).
    logic [14:0] half_cnt;
    logic [30:0] h_prod;
    logic [8:0]  half_q1;

    assign adc_x200   = 18'(i_in_data.adc_value) * 18'd200;
    assign adc_sum    = {3'd0, adc_x200[17:10]} + {1'b0, adc_x200[9:0]};
    assign adc_scaled = adc_x200[17:10] + ((adc_sum >= 11'd1023) ? 8'd1 : 8'd0);
    assign load_val   = 16'(i_cfg.max_seconds) * 16'(adc_scaled);

    assign t_prod   = 32'(r_ticks_left) * 32'd52429;
    assign t_div10  = t_prod[31:19];
    assign t_mult10 = (r_ticks_left == ({t_div10, 3'd0} + {2'd0, t_div10, 1'b0}));

    assign half_cnt = r_ticks_left[15:1];
    assign h_prod   = 31'(half_cnt) * 31'd41944;
    assign half_q1  = h_prod[30:22];

    assign o_in_ready = !r_mid_valid || i_mid_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase       = r_phase;
        n_run_enabled = r_run_enabled;
        n_ticks_left  = r_ticks_left;
        n_press_count = r_press_count;
        n_press_taken = r_press_taken;
        n_hold_left   = r_hold_left;
        n_valve       = r_valve;
        n_disp_mode   = r_disp_mode;
        n_disp_half   = r_disp_half;
        n_disp_q1     = r_disp_q1;

        if (!i_in_data.func) begin
            if (i_in_data.button_low) begin
                if (!r_press_taken) begin
                    if (r_press_count >= i_cfg.debounce_limit) begin
                        n_run_enabled = !r_run_enabled;
                        n_press_taken = 1'b1;
                    end else begin
                        n_press_count = r_press_count + 8'd1;
                    end
                end
            end else begin
                n_press_count = '0;
                n_press_taken = 1'b0;
            end
        end else begin
            unique case (r_phase)
                dcvt_pkg::PH_COUNT: begin
                    if (r_ticks_left == '0 || !r_run_enabled) begin
                        n_run_enabled = 1'b0;
                        n_valve       = 1'b0;
                        n_disp_mode   = dcvt_pkg::DISP_OFF;
                        n_hold_left   = i_cfg.off_hold_ticks;
                        n_phase       = dcvt_pkg::PH_HOLD;
                    end else begin
                        if (t_mult10) begin
                            n_disp_mode = dcvt_pkg::DISP_COUNT;
                            n_disp_half = half_cnt;
                            n_disp_q1   = half_q1;
                        end
                        n_ticks_left = r_ticks_left - 16'd1;
                    end
                end
                dcvt_pkg::PH_HOLD: begin
                    if (r_hold_left == '0) begin
                        n_disp_mode = dcvt_pkg::DISP_HELLO;
                        n_phase     = dcvt_pkg::PH_IDLE;
                    end else begin
                        n_hold_left = r_hold_left - 10'd1;
                    end
                end
                default: begin
                    // idle, and any stray code recovers to idle
                    n_phase = dcvt_pkg::PH_IDLE;
                    if (r_run_enabled) begin
                        n_ticks_left = load_val;
                        n_valve      = 1'b1;
                        n_phase      = dcvt_pkg::PH_COUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= dcvt_pkg::PH_IDLE;
            r_run_enabled <= 1'b0;
            r_ticks_left  <= '0;
            r_press_count <= '0;
            r_press_taken <= 1'b0;
            r_hold_left   <= '0;
            r_valve       <= 1'b0;
            r_disp_mode   <= dcvt_pkg::DISP_HELLO;
            r_mid_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_run_enabled <= n_run_enabled;
                r_ticks_left  <= n_ticks_left;
                r_press_count <= n_press_count;
                r_press_taken <= n_press_taken;
                r_hold_left   <= n_hold_left;
                r_valve       <= n_valve;
                r_disp_mode   <= n_disp_mode;
                r_mid_valid   <= 1'b1;
            end else if (i_mid_ready) begin
                r_mid_valid   <= 1'b0;
            end
        end
    end

    // Display value and snapshot are payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_disp_half <= n_disp_half;
            r_disp_q1   <= n_disp_q1;
            r_mid <= '{valve_on:  n_valve,
                       busy:      (n_phase == dcvt_pkg::PH_COUNT) ||
                                  (n_phase == dcvt_pkg::PH_HOLD),
                       disp_mode: n_disp_mode,
                       disp_half: n_disp_half,
                       disp_q1:   n_disp_q1};
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid_data  = r_mid;

endmodule

>>> design/dcvt_disp.sv
// Segment decode of the display snapshot into the output register.
`timescale 1ns / 1ps

module dcvt_disp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mid_valid,
    output logic                o_mid_ready,
    input  dcvt_pkg::t_mid      i_mid_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dcvt_pkg::t_out_item o_out_data
);

    logic                r_out_valid;
    dcvt_pkg::t_out_item r_out;
    dcvt_pkg::t_out_item out_nxt;
    logic                take;

    logic [14:0] lo_full;
    logic [6:0]  lo_val;
    logic [8:0]  hi_adj;
    logic [6:0]  hi_val;
    logic [3:0]  d0, d1, d2, d3;

    // x / 10 for x < 100: (x * 205) >> 11 is exact there.
    function automatic logic [3:0] div10_small(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10_small(input logic [6:0] x, input logic [3:0] q);
        logic [6:0] r;
        r = x - ({q, 3'd0} + {2'd0, q, 1'b0});
        return r[3:0];
    endfunction

    assign o_mid_ready = !r_out_valid || i_out_ready;
    assign take        = i_mid_valid && o_mid_ready;

    // Low two digits: half - 100*q1. High two digits: q1 mod 100, q1 < 328.
    assign lo_full = i_mid_data.disp_half - (15'(i_mid_data.disp_q1) * 15'd100);
    assign lo_val  = lo_full[6:0];

    always_comb begin
        if (i_mid_data.disp_q1 >= 9'd300) begin
            hi_adj = i_mid_data.disp_q1 - 9'd300;
        end else if (i_mid_data.disp_q1 >= 9'd200) begin
            hi_adj = i_mid_data.disp_q1 - 9'd200;
        end else if (i_mid_data.disp_q1 >= 9'd100) begin
            hi_adj = i_mid_data.disp_q1 - 9'd100;
        end else begin
            hi_adj = i_mid_data.disp_q1;
        end
    end
    assign hi_val = hi_adj[6:0];

    assign d1 = div10_small(lo_val);
    assign d0 = mod10_small(lo_val, d1);
    assign d3 = div10_small(hi_val);
    assign d2 = mod10_small(hi_val, d3);

    always_comb begin
        out_nxt.valve_on = i_mid_data.valve_on;
        out_nxt.busy_res = i_mid_data.busy;
        unique case (i_mid_data.disp_mode)
            dcvt_pkg::DISP_OFF: begin
                out_nxt.seg_units     = dcvt_pkg::SEG_BLANK;
                out_nxt.seg_tens      = dcvt_pkg::SEG_F;
                out_nxt.seg_hundreds  = dcvt_pkg::SEG_F;
                out_nxt.seg_thousands = dcvt_pkg::SEG_O;
            end
            dcvt_pkg::DISP_COUNT: begin
                out_nxt.seg_units     = dcvt_pkg::digit_seg(d0);
                out_nxt.seg_tens      = dcvt_pkg::digit_seg(d1);
                out_nxt.seg_hundreds  = dcvt_pkg::digit_seg(d2) | dcvt_pkg::SEG_DOT;
                out_nxt.seg_thousands = dcvt_pkg::digit_seg(d3);
            end
            default: begin
                out_nxt.seg_units     = dcvt_pkg::SEG_O;
                out_nxt.seg_tens      = dcvt_pkg::SEG_L;
                out_nxt.seg_hundreds  = dcvt_pkg::SEG_E;
                out_nxt.seg_thousands = dcvt_pkg::SEG_H;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= out_nxt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/dcvt_chk.sv
// Port-level checker for the valve timer, bound to the top level.
`timescale 1ns / 1ps

module dcvt_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dcvt_pkg::t_out_item o_out_data
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The valve is only open while busy, that is counting or holding.
    a_valve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valve_on |-> o_out_data.busy_res)
        else $error("valve open while not busy");

    // Idle always shows HELLO.
    a_idle_hello: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.busy_res |->
            o_out_data.seg_units == dcvt_pkg::SEG_O &&
            o_out_data.seg_tens == dcvt_pkg::SEG_L &&
            o_out_data.seg_hundreds == dcvt_pkg::SEG_E &&
            o_out_data.seg_thousands == dcvt_pkg::SEG_H)
        else $error("idle result not showing HELLO");

    // With the output register empty the pipeline must take input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind debounced_countdown_valve_timer dcvt_chk u_dcvt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
